@@ sv/tsg_pkg.sv @@
// Shared types, widths and constants for the tone sweep generator.
// Depends on nothing; imported by tsg_divider, tone_sweep_generator and its testbench.
package tsg_pkg;

   localparam int KNOB_W   = 8;
   localparam int PERIOD_W = 11;
   localparam int DWELL_W  = 9;
   localparam int NUM_W    = 15;
   localparam int SQ_W     = 2 * KNOB_W;

   localparam logic [PERIOD_W-1:0] PERIOD_BASE = PERIOD_W'(65);
   localparam logic [NUM_W-1:0]    DWELL_BASE  = NUM_W'(1397);
   localparam logic [KNOB_W-1:0]   INDEX_TOP   = KNOB_W'(255);

   // Handshake status of the iterative divider.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Half period in microseconds for a pitch code: (k*k >> 6) + 65 + k.
   function automatic logic [PERIOD_W-1:0] pitch_of(input logic [KNOB_W-1:0] k);
      logic [SQ_W-1:0] sq;
      sq = {{KNOB_W{1'b0}}, k} * {{KNOB_W{1'b0}}, k};
      return PERIOD_W'(sq[SQ_W-1:6]) + PERIOD_BASE + PERIOD_W'(k);
   endfunction

endpackage

@@ sv/tsg_divider.sv @@
// Restoring divider, one quotient bit per cycle, for the dwell length.
// Depends on tsg_pkg (widths, div_status_type).
module tsg_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tsg_pkg::NUM_W-1:0]     dividend,
   input  logic [tsg_pkg::PERIOD_W-1:0]  divisor,
   output logic [tsg_pkg::DWELL_W-1:0]   quotient,
   output tsg_pkg::div_status_type       status
);
   import tsg_pkg::*;

   localparam int DSR_W = PERIOD_W + DWELL_W - 1;
   localparam int CNT_W = $clog2(DWELL_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [NUM_W-1:0]    rem_ff, rem_in;
   logic [DSR_W-1:0]    dsr_ff, dsr_in;
   logic [DWELL_W-1:0]  quo_ff, quo_in;
   logic                fits;

   assign fits = {{(DSR_W-NUM_W){1'b0}}, rem_ff} >= dsr_ff;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      quo_in   = quo_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(DWELL_W - 1);
         rem_in   = dividend;
         dsr_in   = {divisor, {(DWELL_W-1){1'b0}}};
         quo_in   = '0;
      end else if (busy_ff) begin
         // subtract the shifted divisor where it fits
         if (fits) begin
            rem_in = rem_ff - dsr_ff[NUM_W-1:0];
         end
         quo_in = {quo_ff[DWELL_W-2:0], fits};
         dsr_in = dsr_ff >> 1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
      quo_ff   <= quo_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

@@ sv/tone_sweep_generator.sv @@
// Tone sweep generator: one knob sample set per transaction, zero or one toggle out.
// Transaction while a sweep runs or arms: accept, divisor, divide steps until done, mirrored
// pitch, commit, toggle registered at commit. Plain tone while idle: accept, rate pitch, commit.
// No new set is taken before commit. Commit holds while a toggle is due and the last still waits.
// Reset (synchronous, active high): sweep idle, pitch index 255, pin low, no result.
// Depends on tsg_pkg and tsg_divider.
module tone_sweep_generator (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [7:0] rate_knob, [15:8] first_knob, [23:16] second_knob
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   // req_tuser: [0] continuous_mode
   input  logic        req_tuser,
   // rsp_tdata: [10:0] half_period_us, [11] tone_level, [15:12] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata
);
   import tsg_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CONT,
      S_DIVISOR,
      S_DIVIDE,
      S_MIRROR,
      S_COMMIT
   } state_type;

   state_type             state_ff, state_in;

   // latched transaction and per-item sweep parameters
   logic [KNOB_W-1:0]     rate_ff, rate_in;
   logic                  cont_ff, cont_in;
   logic [KNOB_W-1:0]     start_ff, start_in;
   logic [KNOB_W-1:0]     end_ff, end_in;
   logic [KNOB_W-1:0]     mirror_ff, mirror_in;
   logic [PERIOD_W-1:0]   next_period_ff, next_period_in;

   // architectural sweep state
   logic                  active_ff, active_in;
   logic [KNOB_W-1:0]     pitch_idx_ff, pitch_idx_in;
   logic [DWELL_W-1:0]    dwell_cnt_ff, dwell_cnt_in;
   logic [PERIOD_W-1:0]   period_ff, period_in;
   logic                  pin_ff, pin_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PERIOD_W-1:0]   rsp_half_ff, rsp_half_in;
   logic                  rsp_level_ff, rsp_level_in;

   logic [KNOB_W-1:0]     knob_rate, knob_a, knob_b;
   logic [KNOB_W-1:0]     pitch_arg;
   logic [PERIOD_W-1:0]   pitch_val;
   logic [NUM_W-1:0]      dividend;
   logic                  div_start;
   logic [DWELL_W-1:0]    dwell_len;
   div_status_type        div_status;
   logic                  emits, out_free;
   logic [DWELL_W-1:0]    dwell_next;
   logic [KNOB_W-1:0]     idx_next;

   assign knob_rate = req_tdata[7:0];
   assign knob_a    = req_tdata[15:8];
   assign knob_b    = req_tdata[23:16];

   assign req_tready = (state_ff == S_IDLE);

   // One pitch evaluator, shared: rate knob for a plain tone, else current index, then mirrored index.
   always_comb begin
      unique case (state_ff)
         S_CONT:    pitch_arg = rate_ff;
         S_DIVISOR: pitch_arg = pitch_idx_ff;
         default:   pitch_arg = mirror_ff;
      endcase
   end
   assign pitch_val = pitch_of(pitch_arg);

   // dwell numerator: (rate << 6) + 1397
   assign dividend  = NUM_W'({rate_ff, 6'b0}) + DWELL_BASE;
   assign div_start = (state_ff == S_DIVISOR);

   tsg_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (pitch_val),
      .quotient (dwell_len),
      .status   (div_status)
   );

   // A toggle comes out of every item except the one that arms a sweep.
   assign emits      = active_ff || cont_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign dwell_next = dwell_cnt_ff + 1'b1;
   assign idx_next   = pitch_idx_ff + 1'b1;

   always_comb begin
      state_in       = state_ff;
      rate_in        = rate_ff;
      cont_in        = cont_ff;
      start_in       = start_ff;
      end_in         = end_ff;
      mirror_in      = mirror_ff;
      next_period_in = next_period_ff;
      active_in      = active_ff;
      pitch_idx_in   = pitch_idx_ff;
      dwell_cnt_in   = dwell_cnt_ff;
      period_in      = period_ff;
      pin_in         = pin_ff;
      rsp_half_in    = rsp_half_ff;
      rsp_level_in   = rsp_level_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               rate_in = knob_rate;
               cont_in = req_tuser;
               // sweep range and mirrored index from the knobs and the current index
               if (knob_a == knob_b) begin
                  start_in  = '0;
                  end_in    = INDEX_TOP;
                  mirror_in = pitch_idx_ff;
               end else if (knob_a < knob_b) begin
                  start_in  = knob_a;
                  end_in    = knob_b;
                  mirror_in = pitch_idx_ff;
               end else begin
                  start_in  = knob_b;
                  end_in    = knob_a;
                  mirror_in = INDEX_TOP - pitch_idx_ff;
               end
               state_in = (!active_ff && req_tuser) ? S_CONT : S_DIVISOR;
            end
         end
         S_CONT: begin
            next_period_in = pitch_val;
            state_in       = S_COMMIT;
         end
         S_DIVISOR: begin
            state_in = S_DIVIDE;
         end
         S_DIVIDE: begin
            if (div_status.done) begin
               state_in = S_MIRROR;
            end
         end
         S_MIRROR: begin
            next_period_in = pitch_val;
            state_in       = S_COMMIT;
         end
         S_COMMIT: begin
            // hold here while a toggle is due and the result register is still full
            if (!emits || out_free) begin
               state_in = S_IDLE;
               if (!active_ff && cont_ff) begin
                  // plain tone
                  period_in    = next_period_ff;
                  pin_in       = !pin_ff;
                  rsp_valid_in = 1'b1;
                  rsp_half_in  = next_period_ff;
                  rsp_level_in = !pin_ff;
               end else if (!active_ff) begin
                  // arm: jump to range start, no toggle
                  pitch_idx_in = start_ff;
                  dwell_cnt_in = '0;
                  if (start_ff < end_ff) begin
                     period_in = next_period_ff;
                     active_in = 1'b1;
                  end
               end else begin
                  // sweep step: toggle, then advance the dwell and maybe the index, or stop on the mode bit
                  pin_in       = !pin_ff;
                  rsp_valid_in = 1'b1;
                  rsp_half_in  = period_ff;
                  rsp_level_in = !pin_ff;
                  dwell_cnt_in = dwell_next;
                  if (cont_ff) begin
                     active_in = 1'b0;
                  end else if (dwell_next >= dwell_len) begin
                     pitch_idx_in = idx_next;
                     if (idx_next < end_ff) begin
                        period_in    = next_period_ff;
                        dwell_cnt_in = '0;
                     end else begin
                        active_in = 1'b0;
                     end
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= 1'b0;
         pitch_idx_ff <= INDEX_TOP;
         dwell_cnt_ff <= '0;
         period_ff    <= '0;
         pin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         pitch_idx_ff <= pitch_idx_in;
         dwell_cnt_ff <= dwell_cnt_in;
         period_ff    <= period_in;
         pin_ff       <= pin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rate_ff        <= rate_in;
      cont_ff        <= cont_in;
      start_ff       <= start_in;
      end_ff         <= end_in;
      mirror_ff      <= mirror_in;
      next_period_ff <= next_period_in;
      rsp_half_ff    <= rsp_half_in;
      rsp_level_ff   <= rsp_level_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_level_ff, rsp_half_ff};

endmodule

@@ tb/tone_sweep_generator_tb.sv @@
// Self-checking testbench for tone_sweep_generator: directed and random knob sample sets,
// with a transaction-level predictor of the tone toggles and random idling on both streams.
// Depends on tsg_pkg and the tone_sweep_generator RTL.
module tone_sweep_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tsg_pkg::*;

   // One knob sample set, packed as it travels: tuser on top, then tdata.
   typedef struct packed {
      logic              cont;
      logic [KNOB_W-1:0] second;
      logic [KNOB_W-1:0] first;
      logic [KNOB_W-1:0] rate;
   } knob_set_type;

   // One toggle of the tone pin as it should appear on rsp_tdata.
   typedef struct packed {
      logic                level;
      logic [PERIOD_W-1:0] period;
   } toggle_type;

   localparam int SWEEP_STOP  = 1;      // mode bit value that selects the plain tone
   localparam int HOLD_OFF    = 400;    // length of the long receiver stall, in cycles
   localparam int DRAIN_WAIT  = 40;     // cycles allowed after the last expected toggle
   localparam int PHASE_ITEMS = 600;    // sample sets queued per idling phase, at least
   localparam int PHASE_LIMIT = 100000; // cycles allowed for one phase to drain

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   knob_set_type knob_sets_pending[$];
   toggle_type   toggles_due[$];

   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int stall_requests = 0;
   int stall_seen     = 0;
   int stall_left     = 0;
   int error_count    = 0;

   // Predictor state, mirrors the block's sweep registers.
   logic                sweep_on   = 1'b0;
   logic [KNOB_W-1:0]   step_index = INDEX_TOP;
   logic [DWELL_W-1:0]  dwell_cnt  = '0;
   logic [DWELL_W-1:0]  dwell_len  = '0;
   logic [KNOB_W-1:0]   range_top  = '0;
   logic [KNOB_W-1:0]   mirror_idx = '0;
   logic [PERIOD_W-1:0] period_now = '0;
   logic                level      = 1'b0;

   tone_sweep_generator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] rate_knob, [15:8] first_knob, [23:16] second_knob
      .req_tuser  (req_tuser),   // [0] continuous_mode
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)    // [10:0] half_period_us, [11] tone_level, [15:12] zero
   );

   always #4 clock = ~clock;

   // Half period in microseconds for a pitch code k: k squared over 64, plus 65, plus k.
   function automatic logic [PERIOD_W-1:0] half_period(input logic [KNOB_W-1:0] k);
      logic [SQ_W-1:0] square;
      square = {{KNOB_W{1'b0}}, k} * {{KNOB_W{1'b0}}, k};
      return PERIOD_W'(square >> 6) + PERIOD_BASE + PERIOD_W'(k);
   endfunction

   // Work out range, mirrored index and dwell from the knobs and the current index.
   task automatic derive_range(input knob_set_type s, output logic [KNOB_W-1:0] start);
      logic [NUM_W-1:0] numer;
      if (s.first == s.second) begin
         start      = '0;
         range_top  = INDEX_TOP;
         mirror_idx = step_index;
      end else if (s.first < s.second) begin
         start      = s.first;
         range_top  = s.second;
         mirror_idx = step_index;
      end else begin
         // Reversed knobs: sweep runs from the high pitch code downwards.
         start      = s.second;
         range_top  = s.first;
         mirror_idx = INDEX_TOP - step_index;
      end
      numer     = {s.rate, 6'b0} + DWELL_BASE;
      dwell_len = DWELL_W'(numer / half_period(step_index));
   endtask

   task automatic toggle_pin();
      level = ~level;
      toggles_due.push_back('{level: level, period: period_now});
   endtask

   // Advance the tone state by one accepted sample set; queue the toggle it causes.
   task automatic advance_tone(input knob_set_type s);
      logic [KNOB_W-1:0] start;
      if (!sweep_on) begin
         if (s.cont) begin
            period_now = half_period(s.rate);
            toggle_pin();
            return;
         end
         // Arming: no toggle, parameters come from the index left by the last sweep.
         derive_range(s, start);
         step_index = start;
         dwell_cnt  = '0;
         if (step_index < range_top) begin
            period_now = half_period(mirror_idx);
            sweep_on   = 1'b1;
         end
         return;
      end
      derive_range(s, start);
      toggle_pin();
      dwell_cnt = dwell_cnt + 1'b1;
      if (s.cont) begin
         sweep_on = 1'b0;
         return;
      end
      if (dwell_cnt >= dwell_len) begin
         step_index = step_index + 1'b1;
         if (step_index < range_top) begin
            period_now = half_period(mirror_idx);
            dwell_cnt  = '0;
         end else begin
            sweep_on = 1'b0;
         end
      end
   endtask

   // Driver: predict on each accepted transaction, then offer the next pending set.
   always @(posedge clock) begin : drive_req
      knob_set_type next_set;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            advance_tone({req_tuser, req_tdata});
         end
         if (!req_tvalid || req_tready) begin
            if (knob_sets_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next_set = knob_sets_pending.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {next_set.second, next_set.first, next_set.rate};
               req_tuser  <= next_set.cont;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random back-pressure, plus a long hold-off whenever one is requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stall_seen != stall_requests) begin
         stall_seen <= stall_requests;
         stall_left <= HOLD_OFF;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Monitor: compare each accepted toggle with the oldest one predicted.
   always @(posedge clock) begin : watch_rsp
      toggle_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (toggles_due.size() == 0) begin
            $error("unexpected toggle: half_period_us %0d tone_level %0d",
                   rsp_tdata[10:0], rsp_tdata[11]);
            error_count++;
         end else begin
            due = toggles_due.pop_front();
            if (rsp_tdata[10:0] !== due.period) begin
               $error("half_period_us: expected %0d, actual %0d", due.period, rsp_tdata[10:0]);
               error_count++;
            end
            if (rsp_tdata[11] !== due.level) begin
               $error("tone_level: expected %0d, actual %0d", due.level, rsp_tdata[11]);
               error_count++;
            end
            if (rsp_tdata[15:12] !== 4'b0) begin
               $error("padding: expected 0, actual %0h", rsp_tdata[15:12]);
               error_count++;
            end
         end
      end
   end

   function automatic knob_set_type knobs(input int rate, input int first, input int second,
                                          input int cont);
      return '{cont: cont[0], second: second[7:0], first: first[7:0], rate: rate[7:0]};
   endfunction

   // Queue an arming set followed by a run of sweep sets over a narrow range, or at times the full range.
   task automatic queue_sweep_run(inout int queued);
      int lo, hi, span, a, b, rate, run_len, order;
      lo      = $urandom_range(0, 254);
      span    = $urandom_range(1, 4);
      hi      = (lo + span > 255) ? 255 : lo + span;
      order   = $urandom_range(0, 9);
      rate    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15);
      run_len = $urandom_range(2, 40);
      if (order < 5) begin
         a = lo; b = hi;
      end else if (order < 9) begin
         a = hi; b = lo;
      end else begin
         a = $urandom_range(0, 255); b = a;
      end
      knob_sets_pending.push_back(knobs(rate, a, b, 0));
      for (int i = 0; i < run_len; i++) begin
         if ($urandom_range(0, 9) == 0) rate = $urandom_range(0, 255);
         knob_sets_pending.push_back(knobs(rate, a, b, 0));
      end
      queued += run_len + 1;
      // Stop the sweep by the mode bit about half the time; otherwise let it run on.
      if ($urandom_range(0, 1) == 1) begin
         knob_sets_pending.push_back(knobs(rate, a, b, SWEEP_STOP));
         queued++;
      end
   endtask

   // Wait until everything queued has gone through and every toggle has come back, or the phase limit.
   task automatic drain();
      int waited;
      waited = 0;
      while ((knob_sets_pending.size() != 0 || req_tvalid || toggles_due.size() != 0)
             && waited < PHASE_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   initial begin : stimulus
      int queued;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 36;
               recv_idle_pct = 78;
            end
            1: begin
               send_idle_pct = 78;
               recv_idle_pct = 36;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               stall_requests++;
            end
         endcase
         queued = 0;
         if (phase == 0) begin
            // Plain tone at both ends of the knob before any sweep.
            knob_sets_pending.push_back(knobs(0, 0, 0, 1));
            knob_sets_pending.push_back(knobs(255, 0, 0, 1));
            queued += 2;
         end
         while (queued < PHASE_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
               knob_sets_pending.push_back(knobs($urandom_range(0, 255), $urandom_range(0, 255),
                                                 $urandom_range(0, 255), 1));
               queued++;
            end else begin
               queue_sweep_run(queued);
            end
         end
         drain();
      end
      if (toggles_due.size() != 0) begin
         $error("toggles: expected %0d more, actual 0", toggles_due.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("tone_sweep_generator_tb passed");
      end else begin
         $display("tone_sweep_generator_tb failed");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("tone_sweep_generator_tb failed");
      $finish;
   end

endmodule

@@ sim.f @@
sv/tsg_pkg.sv
sv/tsg_divider.sv
sv/tone_sweep_generator.sv
tb/tone_sweep_generator_tb.sv
